// ===== rtl/core/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and constants of the quoted string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package qsu_pkg;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_OPEN,
        PH_BODY,
        PH_ESC,
        PH_OCT,
        PH_HEX
    } phase_t;

    // Final status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTQUOTE = 3'd1;
    localparam logic [2:0] ST_UNKESC   = 3'd2;
    localparam logic [2:0] ST_OCTRANGE = 3'd3;
    localparam logic [2:0] ST_HEXNONE  = 3'd4;
    localparam logic [2:0] ST_HEXRANGE = 3'd5;

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Queue sizes
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OBUF_DEPTH  = 4;
    localparam int OPTR_W      = $clog2(OBUF_DEPTH);
    localparam int OCNT_W      = $clog2(OBUF_DEPTH + 1);

    // Classified input item
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       is_bslash;
        logic       is_oct;
        logic       is_hex;
        logic [3:0] hex_val;
    } cls_t;

    // Result item
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] status;
        logic       is_end;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/qsu_if.sv =====
// ----------------------------------------------------------------------------
// qsu_if
// Valid/ready channel interfaces for input bytes and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface qsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       is_end;

    modport source (output valid, output out_byte, output status, output is_end,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input is_end,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qsu_front.sv =====
// ----------------------------------------------------------------------------
// qsu_front
// Accepts raw bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_front
    import qsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    qsu_in_if.sink      in_ch,
    output logic        q_valid,
    output cls_t        q_item,
    input  logic        q_take
);

    cls_t              in_cls;
    cls_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    // Character classification
    always_comb
    begin
        in_cls.data      = in_ch.in_byte;
        in_cls.fin       = in_ch.final_byte;
        in_cls.is_bslash = (in_ch.in_byte == CH_BSLASH);
        in_cls.is_oct    = (in_ch.in_byte >= CH_0) && (in_ch.in_byte <= CH_7);
        in_cls.is_hex    = 1'b1;
        in_cls.hex_val   = in_ch.in_byte[3:0];
        if ((in_ch.in_byte >= CH_0) && (in_ch.in_byte <= CH_9))
        begin
            in_cls.hex_val = in_ch.in_byte[3:0];
        end
        else if (((in_ch.in_byte >= CH_LA) && (in_ch.in_byte <= CH_LF)) ||
                 ((in_ch.in_byte >= CH_UA) && (in_ch.in_byte <= CH_UF)))
        begin
            // low nibble of 'a'..'f' / 'A'..'F' is 1..6
            in_cls.hex_val = in_ch.in_byte[3:0] + 4'd9;
        end
        else
        begin
            in_cls.is_hex = 1'b0;
        end
    end

    // Queue control
    assign in_ch.ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = q_take;
    assign q_valid     = (cnt_reg != '0);
    assign q_item      = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/qsu_back.sv =====
// ----------------------------------------------------------------------------
// qsu_back
// Runs the unescape state machine on classified items and buffers results.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_back
    import qsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cls_t        q_item,
    output logic        q_take,
    qsu_out_if.source   out_ch
);

    phase_t            phase_reg, phase_next;
    logic [7:0]        quote_reg, quote_next;
    logic [7:0]        esc_val_reg, esc_val_next;
    logic              esc_ovf_reg, esc_ovf_next;
    logic              hex_seen_reg, hex_seen_next;
    logic [2:0]        err_reg, err_next;

    result_t           res [2];
    logic [1:0]        nres;
    logic              do_body;
    logic              acc_en;
    logic              acc_hex;
    logic [11:0]       acc_sum;

    result_t           obuf_reg [OBUF_DEPTH];
    logic [OPTR_W-1:0] ord_ptr_reg, ord_ptr_next;
    logic [OPTR_W-1:0] owr_ptr_reg, owr_ptr_next;
    logic [OCNT_W-1:0] ocnt_reg, ocnt_next;
    logic              opop;

    // Take an item only when two result slots are free
    assign q_take = q_valid && (ocnt_reg <= OCNT_W'(OBUF_DEPTH - 2));

    // Numeric escape accumulator
    always_comb
    begin
        if (acc_hex)
        begin
            acc_sum = {esc_val_reg, 4'b0000} + {8'd0, q_item.hex_val};
        end
        else
        begin
            acc_sum = {1'b0, esc_val_reg, 3'b000} + {9'd0, q_item.data[2:0]};
        end
    end

    // Decode one item into up to two results and the next state
    always_comb
    begin
        phase_next    = phase_reg;
        quote_next    = quote_reg;
        esc_val_next  = esc_val_reg;
        esc_ovf_next  = esc_ovf_reg;
        hex_seen_next = hex_seen_reg;
        err_next      = err_reg;
        res[0]        = '0;
        res[1]        = '0;
        nres          = 2'd0;
        do_body       = 1'b0;
        acc_en        = 1'b0;
        acc_hex       = 1'b0;

        if (phase_reg == PH_OPEN)
        begin
            if (q_item.fin)
            begin
                res[0] = '{data: 8'd0, status: ST_NOTQUOTE, is_end: 1'b1};
                nres   = 2'd1;
            end
            else
            begin
                quote_next = q_item.data;
                phase_next = PH_BODY;
                if ((q_item.data != CH_DQUOTE) && (q_item.data != CH_SQUOTE))
                begin
                    err_next = ST_NOTQUOTE;
                end
            end
        end
        else if (err_reg != ST_OK)
        begin
            phase_next = PH_BODY;
            do_body    = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_ESC:
                begin
                    phase_next = PH_BODY;
                    if (q_item.fin)
                    begin
                        err_next = ST_UNKESC;
                        do_body  = 1'b1;
                    end
                    else if (q_item.data == CH_N)
                    begin
                        res[0] = '{data: CH_NL, status: ST_OK, is_end: 1'b0};
                        nres   = 2'd1;
                    end
                    else if (q_item.data == CH_R)
                    begin
                        res[0] = '{data: CH_CR, status: ST_OK, is_end: 1'b0};
                        nres   = 2'd1;
                    end
                    else if (q_item.is_bslash || (q_item.data == CH_DQUOTE) ||
                             (q_item.data == CH_SQUOTE))
                    begin
                        res[0] = '{data: q_item.data, status: ST_OK, is_end: 1'b0};
                        nres   = 2'd1;
                    end
                    else if (q_item.is_oct)
                    begin
                        esc_val_next = {5'd0, q_item.data[2:0]};
                        esc_ovf_next = 1'b0;
                        phase_next   = PH_OCT;
                    end
                    else if (q_item.data == CH_X)
                    begin
                        esc_val_next  = 8'd0;
                        esc_ovf_next  = 1'b0;
                        hex_seen_next = 1'b0;
                        phase_next    = PH_HEX;
                    end
                    else
                    begin
                        err_next = ST_UNKESC;
                    end
                end
                PH_OCT:
                begin
                    if (!q_item.fin && q_item.is_oct)
                    begin
                        acc_en = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        if (esc_ovf_reg)
                        begin
                            err_next = ST_OCTRANGE;
                        end
                        else
                        begin
                            res[0] = '{data: esc_val_reg, status: ST_OK, is_end: 1'b0};
                            nres   = 2'd1;
                        end
                        esc_val_next = 8'd0;
                        esc_ovf_next = 1'b0;
                        do_body      = 1'b1;
                    end
                end
                PH_HEX:
                begin
                    acc_hex = 1'b1;
                    if (!q_item.fin && q_item.is_hex)
                    begin
                        acc_en        = 1'b1;
                        hex_seen_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        if (!hex_seen_reg)
                        begin
                            err_next = ST_HEXNONE;
                        end
                        else if (esc_ovf_reg)
                        begin
                            err_next = ST_HEXRANGE;
                        end
                        else
                        begin
                            res[0] = '{data: esc_val_reg, status: ST_OK, is_end: 1'b0};
                            nres   = 2'd1;
                        end
                        esc_val_next  = 8'd0;
                        esc_ovf_next  = 1'b0;
                        hex_seen_next = 1'b0;
                        do_body       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_BODY;
                    do_body    = 1'b1;
                end
            endcase
        end

        // Saturating accumulate
        if (acc_en)
        begin
            if (acc_sum > 12'd255)
            begin
                esc_val_next = 8'hFF;
                esc_ovf_next = 1'b1;
            end
            else
            begin
                esc_val_next = acc_sum[7:0];
            end
        end

        // Ordinary body byte, after any escape has been closed
        if (do_body)
        begin
            if (q_item.fin)
            begin
                res[nres[0]] = '{data: 8'd0,
                                 status: (q_item.data != quote_reg) ? ST_NOTQUOTE
                                                                    : err_next,
                                 is_end: 1'b1};
                nres = nres + 2'd1;
            end
            else if (err_next == ST_OK)
            begin
                if (q_item.is_bslash)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    res[nres[0]] = '{data: q_item.data, status: ST_OK, is_end: 1'b0};
                    nres = nres + 2'd1;
                end
            end
        end

        // End of literal clears the literal state
        if (q_item.fin)
        begin
            phase_next    = PH_OPEN;
            quote_next    = 8'd0;
            esc_val_next  = 8'd0;
            esc_ovf_next  = 1'b0;
            hex_seen_next = 1'b0;
            err_next      = ST_OK;
        end
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OPEN;
            quote_reg    <= 8'd0;
            esc_val_reg  <= 8'd0;
            esc_ovf_reg  <= 1'b0;
            hex_seen_reg <= 1'b0;
            err_reg      <= ST_OK;
        end
        else if (q_take)
        begin
            phase_reg    <= phase_next;
            quote_reg    <= quote_next;
            esc_val_reg  <= esc_val_next;
            esc_ovf_reg  <= esc_ovf_next;
            hex_seen_reg <= hex_seen_next;
            err_reg      <= err_next;
        end
    end

    // Output buffer control
    assign opop            = out_ch.valid && out_ch.ready;
    assign out_ch.valid    = (ocnt_reg != '0);
    assign out_ch.out_byte = obuf_reg[ord_ptr_reg].data;
    assign out_ch.status   = obuf_reg[ord_ptr_reg].status;
    assign out_ch.is_end   = obuf_reg[ord_ptr_reg].is_end;

    always_comb
    begin
        owr_ptr_next = q_take ? owr_ptr_reg + OPTR_W'(nres) : owr_ptr_reg;
        ord_ptr_next = opop ? ord_ptr_reg + 1'b1 : ord_ptr_reg;
        ocnt_next    = ocnt_reg + (q_take ? OCNT_W'(nres) : '0) - OCNT_W'(opop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocnt_reg    <= '0;
        end
        else
        begin
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocnt_reg    <= ocnt_next;
        end
    end

    // Output buffer storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (q_take && (nres != 2'd0))
        begin
            obuf_reg[owr_ptr_reg] <= res[0];
        end
        if (q_take && (nres == 2'd2))
        begin
            obuf_reg[owr_ptr_reg + 1'b1] <= res[1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/quoted_string_unescaper_unit.sv =====
// ----------------------------------------------------------------------------
// quoted_string_unescaper_unit
// Decodes a quoted C-style literal byte by byte into bytes and a status.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                      Accept
//  in_ch    in   in_byte[8], final_byte[1]    valid & ready
//  out_ch   out  out_byte[8], status[3],      valid & ready
//                is_end[1]
//
//  One input item per cycle sustained unless the output buffer holds the
//  decoder; each item yields zero, one or two results, and the output side
//  drains one result per cycle while out_ch.ready is high. An accepted item
//  lands in the input queue, and when the decoder takes it, its results are
//  written into the output buffer. A four-entry input queue and a four-entry
//  output buffer decouple the two sides; the decoder takes an item only when
//  two output slots are free. rst_n clears all control state asynchronously.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_string_unescaper_unit
    import qsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    qsu_in_if.sink      in_ch,
    qsu_out_if.source   out_ch
);

    logic q_valid;
    cls_t q_item;
    logic q_take;

    // Front: accept and classify
    qsu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    // Back: decode and buffer results
    qsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire
